FILE: src/qse_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature speed estimator package
// Shared widths, codes and constants for the speed estimator and its
// serial arithmetic units.
// ----------------------------------------------------------------------------
package qse_pkg;

	// Default parameter values.
	localparam int INTERVAL_WIDTH_DEF = 24;
	localparam int POSITION_WIDTH_DEF = 16;

	// Fixed field widths.
	localparam int KIND_W   = 2;
	localparam int OUT_POS_W = 16;
	localparam int SPEED_W  = 24;
	localparam int CPS_W    = 15;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 1;
	localparam int ACCEL_W  = 42;

	// Acceleration gain, applied by a serial shift-add multiplier.
	localparam int GAIN_W = 17;
	localparam logic [GAIN_W-1:0] ACCEL_GAIN = 17'd100000;
	localparam int PRODUCT_W = SPEED_W + GAIN_W;

	// Input event codes.
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EDGE_A = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EDGE_B = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_SCALE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_STEP = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [SPEED_W-1:0] VELOCITY_SCALE_RST  = 24'd100000;
	localparam logic [CPS_W-1:0]   COUNTS_PER_STEP_RST = 15'd4;

endpackage

FILE: src/qse_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle. The dividend shifts out
// at the top while quotient bits shift in at the bottom of the same register.
// ----------------------------------------------------------------------------
module qse_div #(
	parameter int DW = 24,
	parameter int VW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [DW-1:0] dvd_q;

	logic [VW:0]   trial;
	logic [VW+1:0] sub;
	logic          ge;
	logic [VW-1:0] rem_next;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial    = {rem_q, dvd_q[DW-1]};
		sub      = {1'b0, trial} - {2'b00, dsr_q};
		ge       = !sub[VW+1];
		rem_next = ge ? sub[VW-1:0] : trial[VW-1:0];
	end

	// Control: count one step per quotient bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: src/qse_mul.sv
// ----------------------------------------------------------------------------
// Serial gain multiplier
// Multiplies a speed difference magnitude by the acceleration gain, one
// gain bit per cycle with a shift-add accumulator.
// ----------------------------------------------------------------------------
module qse_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [qse_pkg::SPEED_W-1:0]   mcand,
	output logic                          done,
	output logic [qse_pkg::PRODUCT_W-1:0] product
);

	import qse_pkg::*;

	localparam int CW = $clog2(GAIN_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [PRODUCT_W-1:0] mc_q;
	logic [PRODUCT_W-1:0] prod_q;

	// Control: one step per gain bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: add the shifted multiplicand where the gain bit is set.
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q   <= PRODUCT_W'(mcand);
			gain_q <= ACCEL_GAIN;
			prod_q <= '0;
		end else if (busy_q) begin
			if (gain_q[0]) begin
				prod_q <= prod_q + mc_q;
			end
			mc_q   <= {mc_q[PRODUCT_W-2:0], 1'b0};
			gain_q <= {1'b0, gain_q[GAIN_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

FILE: src/quadrature_speed_estimator.sv
// ----------------------------------------------------------------------------
// Quadrature speed estimator
// Counts encoder position from phase edges and, on each count, reports
// position, pinion position, period-based speed and acceleration.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  kind, phase_a_level, phase_b_level
//   out      output     out_valid / out_stall position, pinion_position,
//                                            speed, accel
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// A tick or a non-counting edge is taken while idle. For a counting edge the
// speed divider, the serial gain multiplier and the acceleration divider
// run one after another; the pinion divider runs alongside the speed divider.
// in_stall stays high while a count is being worked on. A finished result
// waits in the output register; a new count may start while it waits.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module quadrature_speed_estimator #(
	parameter int INTERVAL_WIDTH = qse_pkg::INTERVAL_WIDTH_DEF,
	parameter int POSITION_WIDTH = qse_pkg::POSITION_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [qse_pkg::KIND_W-1:0]          kind,
	input  logic                                phase_a_level,
	input  logic                                phase_b_level,
	// Output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [qse_pkg::OUT_POS_W-1:0] position,
	output logic signed [qse_pkg::OUT_POS_W-1:0] pinion_position,
	output logic [qse_pkg::SPEED_W-1:0]         speed,
	output logic signed [qse_pkg::ACCEL_W-1:0]  accel,
	// Configuration port
	input  logic                                cfg_we,
	input  logic [qse_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [qse_pkg::CFG_W-1:0]           cfg_data
);

	import qse_pkg::*;

	localparam int IW = INTERVAL_WIDTH;
	localparam int PW = POSITION_WIDTH;

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_SPEED = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_ACCEL = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [SPEED_W-1:0] scale_q;
	logic [CPS_W-1:0]   cps_q;
	logic [PW-1:0]      pos_q;
	logic [SPEED_W-1:0] last_speed_q;
	logic [IW-1:0]      interval_q;
	logic [IW-1:0]      iv_q;
	logic               pin_neg_q;
	logic [PW-1:0]      pin_res_q;
	logic               acc_neg_q;
	logic [SPEED_W-1:0] spd_q;

	logic                 out_valid_q;
	logic [OUT_POS_W-1:0] position_q;
	logic [OUT_POS_W-1:0] pinion_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [ACCEL_W-1:0]   accel_q;

	logic in_take;
	logic count_up;
	logic count_dn;
	logic out_free;

	logic [PW-1:0]      pin_mag;
	logic [CPS_W-1:0]   pin_dsr;
	logic               pin_done;
	logic [PW-1:0]      pin_quo;
	logic               spd_done;
	logic [SPEED_W-1:0] spd_quo;
	logic               mul_done;
	logic [PRODUCT_W-1:0] mul_prod;
	logic               acc_done;
	logic [PRODUCT_W-1:0] acc_quo;

	logic [SPEED_W:0]   dsum;
	logic [SPEED_W:0]   dneg;
	logic [SPEED_W-1:0] dmag;

	logic [PW:0]          pin_full;
	logic [ACCEL_W-1:0]   acc_full;
	logic [OUT_POS_W-1:0] pos_out;
	logic [OUT_POS_W-1:0] pin_out;

	// Handshake and edge decode.
	always_comb begin
		in_take  = in_valid && !in_stall;
		count_up = (kind == KIND_EDGE_A) && !phase_b_level;
		count_dn = (kind == KIND_EDGE_B) && !phase_a_level;
		out_free = !out_valid_q || !out_stall;
	end

	assign in_stall = (state_q != ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= VELOCITY_SCALE_RST;
			cps_q   <= COUNTS_PER_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VELOCITY_SCALE:  scale_q <= cfg_data;
				REG_COUNTS_PER_STEP: cps_q   <= cfg_data[CPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Speed difference against the previous speed, as sign and magnitude.
	always_comb begin
		dsum = {1'b0, spd_quo} - {1'b0, last_speed_q};
		dneg = -dsum;
		dmag = dsum[SPEED_W] ? dneg[SPEED_W-1:0] : dsum[SPEED_W-1:0];
	end

	// Pinion divider operands from the counted position.
	always_comb begin
		pin_mag = pos_q[PW-1] ? (-pos_q) : pos_q;
		pin_dsr = (cps_q == '0) ? CPS_W'(1) : cps_q;
	end

	// Sequencer and estimator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			last_speed_q <= '0;
			interval_q   <= IW'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (kind == KIND_TICK) begin
							if (interval_q != {IW{1'b1}}) begin
								interval_q <= interval_q + IW'(1);
							end
						end else if (count_up || count_dn) begin
							pos_q      <= count_up ? pos_q + PW'(1) : pos_q - PW'(1);
							interval_q <= '0;
							state_q    <= ST_START;
						end
					end
				end
				ST_START: state_q <= ST_SPEED;
				ST_SPEED: begin
					if (spd_done) begin
						last_speed_q <= spd_quo;
						state_q      <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_ACCEL;
					end
				end
				ST_ACCEL: begin
					if (acc_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Per-count working registers. With default widths the pinion divider finishes
	// before the acceleration divider, so its quotient is held here until the end.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_take && (count_up || count_dn)) begin
			iv_q <= (interval_q == '0) ? IW'(1) : interval_q;
		end
		if (state_q == ST_START) begin
			pin_neg_q <= pos_q[PW-1];
		end
		if (pin_done) begin
			pin_res_q <= pin_quo;
		end
		if (state_q == ST_SPEED && spd_done) begin
			spd_q     <= spd_quo;
			acc_neg_q <= dsum[SPEED_W];
		end
	end

	// Pinion position divider.
	qse_div #(
		.DW(PW),
		.VW(CPS_W)
	) u_pin_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.dividend (pin_mag),
		.divisor  (pin_dsr),
		.done     (pin_done),
		.quotient (pin_quo)
	);

	// Speed divider.
	qse_div #(
		.DW(SPEED_W),
		.VW(IW)
	) u_spd_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.dividend (scale_q),
		.divisor  (iv_q),
		.done     (spd_done),
		.quotient (spd_quo)
	);

	// Gain multiplier on the speed difference.
	qse_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_SPEED && spd_done),
		.mcand   (dmag),
		.done    (mul_done),
		.product (mul_prod)
	);

	// Acceleration divider.
	qse_div #(
		.DW(PRODUCT_W),
		.VW(IW)
	) u_acc_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MUL && mul_done),
		.dividend (mul_prod),
		.divisor  (iv_q),
		.done     (acc_done),
		.quotient (acc_quo)
	);

	// Reapply signs to the quotient magnitudes.
	always_comb begin
		pin_full = pin_neg_q ? (-{1'b0, pin_res_q}) : {1'b0, pin_res_q};
		acc_full = acc_neg_q ? (-{1'b0, acc_quo}) : {1'b0, acc_quo};
	end

	// Fit position and pinion position to the output width, sign extending narrow values.
	generate
		if (PW >= OUT_POS_W) begin : g_pos_trunc
			assign pos_out = pos_q[OUT_POS_W-1:0];
		end else begin : g_pos_ext
			assign pos_out = {{(OUT_POS_W-PW){pos_q[PW-1]}}, pos_q};
		end
		if (PW + 1 >= OUT_POS_W) begin : g_pin_trunc
			assign pin_out = pin_full[OUT_POS_W-1:0];
		end else begin : g_pin_ext
			assign pin_out = {{(OUT_POS_W-PW-1){pin_full[PW]}}, pin_full};
		end
	endgenerate

	// Output register: a result waits here until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			position_q <= pos_out;
			pinion_q   <= pin_out;
			speed_q    <= spd_q;
			accel_q    <= acc_full;
		end
	end

	assign out_valid       = out_valid_q;
	assign position        = position_q;
	assign pinion_position = pinion_q;
	assign speed           = speed_q;
	assign accel           = accel_q;

endmodule

FILE: bench/quadrature_speed_estimator_tb.sv
// ----------------------------------------------------------------------------
// Quadrature speed estimator testbench
// Drives ticks and encoder phase edges into the estimator and predicts each
// position, pinion position, speed and acceleration reading in step with
// the accepted transactions. Covers the counting rules, register extremes,
// a long tick run and random traffic under several idle patterns on both
// channels.
// ----------------------------------------------------------------------------
module quadrature_speed_estimator_tb;
	import qse_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES   = 128;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int LONG_RUN_TICKS  = 300;
	localparam longint CYCLE_LIMIT = 2000000;

	// One reading as the output channel presents it.
	typedef struct {
		logic signed [OUT_POS_W-1:0] position;
		logic signed [OUT_POS_W-1:0] pinion;
		logic [SPEED_W-1:0]          speed;
		logic signed [ACCEL_W-1:0]   accel;
	} reading_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [KIND_W-1:0]           kind;
	logic                        phase_a_level;
	logic                        phase_b_level;
	logic                        out_valid;
	logic                        out_stall;
	logic signed [OUT_POS_W-1:0] position;
	logic signed [OUT_POS_W-1:0] pinion_position;
	logic [SPEED_W-1:0]          speed;
	logic signed [ACCEL_W-1:0]   accel;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_data;

	// Predicted state of the estimator.
	logic [OUT_POS_W-1:0] count_pos;
	logic [SPEED_W-1:0]   prev_speed;
	logic [23:0]          ticks_since;
	logic [SPEED_W-1:0]   scale_reg;
	logic [CPS_W-1:0]     step_reg;

	reading_t readings_due[$];
	reading_t due;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned error_count;
	longint cycle_count;

	quadrature_speed_estimator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.phase_a_level  (phase_a_level),
		.phase_b_level  (phase_b_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position       (position),
		.pinion_position(pinion_position),
		.speed          (speed),
		.accel          (accel),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("quadrature_speed_estimator_tb NOT OK");
			$finish;
		end
	end

	// Updates the predicted state for one event and returns 1 when the event
	// produces a reading.
	function automatic bit compute_reading(input logic [KIND_W-1:0] k, input logic a,
			input logic b, output reading_t r);
		longint pos_s;
		longint divisor;
		longint pin_s;
		longint iv;
		longint spd;
		longint diff;
		longint acc;
		if (k == KIND_TICK) begin
			if (ticks_since != '1)
				ticks_since = ticks_since + 24'd1;
			return 1'b0;
		end
		if (k == KIND_EDGE_A && !b)
			count_pos = count_pos + 16'd1;
		else if (k == KIND_EDGE_B && !a)
			count_pos = count_pos - 16'd1;
		else
			return 1'b0;

		// Pinion position truncates toward zero; a zero step count acts as one.
		pos_s = longint'($signed(count_pos));
		divisor = (step_reg == '0) ? 64'sd1 : longint'(step_reg);
		pin_s = pos_s / divisor;

		// A count with no tick since the last one divides by one.
		iv = (ticks_since == '0) ? 64'sd1 : longint'(ticks_since);
		spd = longint'(scale_reg) / iv;
		diff = spd - longint'(prev_speed);
		acc = diff * longint'(ACCEL_GAIN) / iv;

		prev_speed = spd[SPEED_W-1:0];
		ticks_since = '0;
		r.position = count_pos;
		r.pinion = pin_s[OUT_POS_W-1:0];
		r.speed = spd[SPEED_W-1:0];
		r.accel = acc[ACCEL_W-1:0];
		return 1'b1;
	endfunction

	// Sends one event transaction, with an optional idle gap before it.
	task automatic send_event(input logic [KIND_W-1:0] k, input logic a, input logic b);
		reading_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		kind <= k;
		phase_a_level <= a;
		phase_b_level <= b;
		do @(posedge clk); while (in_stall);
		if (compute_reading(k, a, b, r))
			readings_due.push_back(r);
	endtask

	// Waits until every predicted reading has arrived and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers while the block is idle.
	task automatic set_registers(input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] cps);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_VELOCITY_SCALE;
		cfg_data <= scale;
		@(posedge clk);
		cfg_index <= REG_COUNTS_PER_STEP;
		cfg_data <= cps;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_reg = scale[SPEED_W-1:0];
		step_reg = cps[CPS_W-1:0];
	endtask

	// Counting rules at the reset register values: ignored edges, unused
	// kind, zero interval, counting down through zero, negative pinion.
	task automatic test_count_rules();
		send_event(KIND_EDGE_A, 1'b1, 1'b0);
		send_event(KIND_EDGE_A, 1'b1, 1'b1);
		send_event(KIND_EDGE_B, 1'b1, 1'b1);
		send_event(KIND_UNUSED, 1'b1, 1'b1);
		send_event(KIND_UNUSED, 1'b0, 1'b0);
		send_event(KIND_EDGE_B, 1'b0, 1'b1);
		send_event(KIND_TICK, 1'b0, 1'b0);
		send_event(KIND_TICK, 1'b1, 1'b1);
		send_event(KIND_EDGE_B, 1'b0, 1'b0);
		repeat (5) begin
			send_event(KIND_TICK, 1'b1, 1'b0);
			send_event(KIND_EDGE_B, 1'b0, 1'b1);
		end
		send_event(KIND_EDGE_A, 1'b0, 1'b0);
	endtask

	// Register extremes: full scale, zero and full step counts, zero scale.
	task automatic test_register_extremes();
		set_registers(24'hFFFFFF, 24'd0);
		send_event(KIND_EDGE_A, 1'b1, 1'b0);
		send_event(KIND_EDGE_A, 1'b0, 1'b0);
		set_registers(24'd0, 24'h007FFF);
		send_event(KIND_TICK, 1'b0, 1'b1);
		send_event(KIND_EDGE_B, 1'b0, 1'b1);
		set_registers(24'd1, 24'd1);
		send_event(KIND_TICK, 1'b0, 1'b0);
		send_event(KIND_TICK, 1'b0, 1'b0);
		send_event(KIND_EDGE_A, 1'b1, 1'b0);
		send_event(KIND_EDGE_A, 1'b1, 1'b0);
	endtask

	// Long tick run: the interval grows well past 8 bits before a count.
	task automatic test_long_interval();
		set_registers(24'hFFFFFF, 24'd4);
		send_event(KIND_EDGE_A, 1'b0, 1'b0);
		repeat (LONG_RUN_TICKS)
			send_event(KIND_TICK, 1'b0, 1'b0);
		send_event(KIND_EDGE_A, 1'b0, 1'b0);
		send_event(KIND_EDGE_B, 1'b0, 1'b0);
	endtask

	// Random encoder traffic: tick runs of mixed length followed by an edge,
	// mostly counting in a direction that changes now and then, with some
	// edges blocked by the other phase and some random noise events.
	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] cps);
		int unsigned sent;
		int unsigned run;
		int unsigned r;
		bit up;
		bit blocked;
		set_registers(scale, cps);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		up = 1'b1;
		while (sent < ITEMS_PER_PHASE) begin
			r = $urandom_range(99);
			if (r < 8) begin
				send_event(KIND_W'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				r = $urandom_range(99);
				if (r < 40)
					run = 0;
				else if (r < 80)
					run = $urandom_range(3, 1);
				else if (r < 97)
					run = $urandom_range(20, 4);
				else
					run = $urandom_range(255, 21);
				sent += run;
				repeat (run)
					send_event(KIND_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));

				if ($urandom_range(99) < 15)
					up = !up;
				blocked = ($urandom_range(99) < 10);
				if (up)
					send_event(KIND_EDGE_A, 1'($urandom_range(1)), blocked);
				else
					send_event(KIND_EDGE_B, blocked, 1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	// Output checking and receiver stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected reading position %0d speed %0d", $time,
						position, speed);
					error_count++;
				end else begin
					due = readings_due.pop_front();
					if (position !== due.position) begin
						$display("%0t: position expected %0d actual %0d", $time,
							due.position, position);
						error_count++;
					end
					if (pinion_position !== due.pinion) begin
						$display("%0t: pinion_position expected %0d actual %0d", $time,
							due.pinion, pinion_position);
						error_count++;
					end
					if (speed !== due.speed) begin
						$display("%0t: speed expected %0d actual %0d", $time,
							due.speed, speed);
						error_count++;
					end
					if (accel !== due.accel) begin
						$display("%0t: accel expected %0d actual %0d", $time,
							due.accel, accel);
						error_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		phase_a_level = 1'b0;
		phase_b_level = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_VELOCITY_SCALE;
		cfg_data = '0;
		cycle_count = 0;
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		count_pos = '0;
		prev_speed = '0;
		ticks_since = 24'd1;
		scale_reg = VELOCITY_SCALE_RST;
		step_reg = COUNTS_PER_STEP_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_count_rules();
		test_register_extremes();
		test_long_interval();
		test_random_traffic(14, 74, CFG_W'($urandom_range(24'hFFFFFF, 1)),
			CFG_W'($urandom_range(8, 1)));
		test_random_traffic(74, 14, 24'hFFFFFF, 24'h007FFF);
		test_random_traffic(0, 0, CFG_W'($urandom_range(4000, 1)),
			CFG_W'($urandom_range(16, 1)));

		settle();
		if (error_count == 0)
			$display("quadrature_speed_estimator_tb OK");
		else
			$display("quadrature_speed_estimator_tb NOT OK");
		$finish;
	end

endmodule

FILE: quadrature_speed_estimator.f
src/qse_pkg.sv
src/qse_div.sv
src/qse_mul.sv
src/quadrature_speed_estimator.sv
bench/quadrature_speed_estimator_tb.sv
